>>> hdl/assert_macros.svh
// Assertion macros shared by the tokenizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define QAT_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("tokenizer assertion failed");

// Check that a trigger implies a consequence in the same cycle.
`define QAT_ASSERT_IMPL(lbl, trig, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cons)) \
      else $error("tokenizer assertion failed");

// Check that a trigger implies a consequence in the next cycle.
`define QAT_ASSERT_NEXT(lbl, trig, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error("tokenizer assertion failed");

`endif

>>> hdl/qat_pkg.sv
// Types, constants and character helpers for the quoted argument tokenizer.
`default_nettype none

package qat_pkg;

   localparam int unsigned QAT_FIFO_DEPTH = 4;
   localparam int unsigned COUNT_W        = 10;
   localparam logic [COUNT_W-1:0] ARG_COUNT_MAX = '1;

   localparam logic [7:0] CH_NUL       = 8'h00;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_VTAB      = 8'h0B;
   localparam logic [7:0] CH_FORMFEED  = 8'h0C;
   localparam logic [7:0] CH_RETURN    = 8'h0D;
   localparam logic [7:0] CH_BACKSPACE = 8'h08;
   localparam logic [7:0] CH_BELL      = 8'h07;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_SQUOTE    = 8'h27;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_LOWER_N   = 8'h6E;
   localparam logic [7:0] CH_LOWER_R   = 8'h72;
   localparam logic [7:0] CH_LOWER_T   = 8'h74;
   localparam logic [7:0] CH_LOWER_B   = 8'h62;
   localparam logic [7:0] CH_LOWER_A   = 8'h61;

   typedef enum logic [2:0] {
      MODE_SKIP   = 3'd0,
      MODE_PLAIN  = 3'd1,
      MODE_DQ     = 3'd2,
      MODE_DQ_ESC = 3'd3,
      MODE_SQ     = 3'd4,
      MODE_SQ_ESC = 3'd5,
      MODE_CLOSED = 3'd6,
      MODE_DROP   = 3'd7
   } mode_type;

   typedef enum logic [1:0] {
      KIND_BYTE = 2'd0,
      KIND_END  = 2'd1,
      KIND_OK   = 2'd2,
      KIND_ERR  = 2'd3
   } kind_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       line_end;
   } req_type;

   typedef struct packed {
      logic [7:0]         out_byte;
      kind_type           kind;
      logic [COUNT_W-1:0] arg_count;
   } rsp_type;

   // Up to two results produced by one input item, first in order.
   typedef struct packed {
      logic [1:0] num;
      rsp_type    first;
      rsp_type    second;
   } rsp_pair_type;

   typedef struct packed {
      mode_type           mode;
      logic [COUNT_W-1:0] count;
   } parse_state_type;

   // Outcome of handling one character in a sub-mode.
   typedef struct packed {
      logic     emit;
      rsp_type  rsp;
      mode_type mode;
      logic     bump;
   } step_type;

   function automatic rsp_type arg_byte(input logic [7:0] c);
      rsp_type r;
      r.out_byte  = c;
      r.kind      = KIND_BYTE;
      r.arg_count = '0;
      return r;
   endfunction

   function automatic rsp_type arg_end();
      rsp_type r;
      r.out_byte  = '0;
      r.kind      = KIND_END;
      r.arg_count = '0;
      return r;
   endfunction

   function automatic rsp_type line_status(input kind_type k,
                                           input logic [COUNT_W-1:0] cnt);
      rsp_type r;
      r.out_byte  = '0;
      r.kind      = k;
      r.arg_count = cnt;
      return r;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NEWLINE) ||
             (c == CH_VTAB) || (c == CH_FORMFEED) || (c == CH_RETURN);
   endfunction

   function automatic logic is_term(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NEWLINE) || (c == CH_RETURN);
   endfunction

   function automatic logic [7:0] dq_escape(input logic [7:0] c);
      logic [7:0] r;
      case (c)
         CH_LOWER_N: r = CH_NEWLINE;
         CH_LOWER_R: r = CH_RETURN;
         CH_LOWER_T: r = CH_TAB;
         CH_LOWER_B: r = CH_BACKSPACE;
         CH_LOWER_A: r = CH_BELL;
         default:    r = c;
      endcase
      return r;
   endfunction

   // Character in unquoted text, or the first character of an argument.
   function automatic step_type plain_step(input logic [7:0] c);
      step_type s;
      s.emit = 1'b0;
      s.rsp  = '0;
      s.mode = MODE_PLAIN;
      s.bump = 1'b0;
      if (is_term(c)) begin
         s.emit = 1'b1;
         s.rsp  = arg_end();
         s.mode = MODE_SKIP;
         s.bump = 1'b1;
      end else if (c == CH_DQUOTE) begin
         s.mode = MODE_DQ;
      end else if (c == CH_SQUOTE) begin
         s.mode = MODE_SQ;
      end else begin
         s.emit = 1'b1;
         s.rsp  = arg_byte(c);
      end
      return s;
   endfunction

   // Character inside single quotes.
   function automatic step_type sq_step(input logic [7:0] c);
      step_type s;
      s.emit = 1'b0;
      s.rsp  = '0;
      s.mode = MODE_SQ;
      s.bump = 1'b0;
      if (c == CH_BACKSLASH) begin
         s.mode = MODE_SQ_ESC;
      end else if (c == CH_SQUOTE) begin
         s.mode = MODE_CLOSED;
      end else begin
         s.emit = 1'b1;
         s.rsp  = arg_byte(c);
      end
      return s;
   endfunction

endpackage

`default_nettype wire

>>> hdl/qat_parser.sv
// Parse mode machine: one character or line end per transfer, up to two results.
`default_nettype none

module qat_parser (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      advance,
   input  qat_pkg::req_type         item,
   output qat_pkg::rsp_pair_type    pair,
   output qat_pkg::parse_state_type state
);
   import qat_pkg::*;

   mode_type           mode_ff, mode_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] count_sat;
   logic [7:0]         c;
   step_type           plain_s, sq_s;

   assign c         = item.in_byte;
   assign count_sat = (count_ff == ARG_COUNT_MAX) ? count_ff : count_ff + 1'b1;
   assign plain_s   = plain_step(c);
   assign sq_s      = sq_step(c);

   always_comb begin
      pair     = '0;
      mode_in  = mode_ff;
      count_in = count_ff;
      if (item.line_end) begin
         pair.num = 2'd1;
         mode_in  = MODE_SKIP;
         count_in = '0;
         case (mode_ff)
            MODE_SKIP: begin
               pair.first = line_status(KIND_OK, count_ff);
            end
            MODE_PLAIN, MODE_CLOSED: begin
               pair.num    = 2'd2;
               pair.first  = arg_end();
               pair.second = line_status(KIND_OK, count_sat);
            end
            default: begin
               pair.first = line_status(KIND_ERR, count_ff);
            end
         endcase
      end else if (c != CH_NUL) begin
         case (mode_ff)
            MODE_SKIP, MODE_PLAIN: begin
               // blanks between arguments are skipped
               if (mode_ff == MODE_PLAIN || !is_blank(c)) begin
                  pair.num   = {1'b0, plain_s.emit};
                  pair.first = plain_s.rsp;
                  mode_in    = plain_s.mode;
                  if (plain_s.bump) count_in = count_sat;
               end
            end
            MODE_DQ: begin
               if (c == CH_BACKSLASH) begin
                  mode_in = MODE_DQ_ESC;
               end else if (c == CH_DQUOTE) begin
                  mode_in = MODE_CLOSED;
               end else begin
                  pair.num   = 2'd1;
                  pair.first = arg_byte(c);
               end
            end
            MODE_DQ_ESC: begin
               pair.num   = 2'd1;
               pair.first = arg_byte(dq_escape(c));
               mode_in    = MODE_DQ;
            end
            MODE_SQ: begin
               pair.num   = {1'b0, sq_s.emit};
               pair.first = sq_s.rsp;
               mode_in    = sq_s.mode;
            end
            MODE_SQ_ESC: begin
               if (c == CH_SQUOTE) begin
                  pair.num   = 2'd1;
                  pair.first = arg_byte(CH_SQUOTE);
                  mode_in    = MODE_SQ;
               end else begin
                  // keep the backslash, then handle the character as usual
                  pair.num    = sq_s.emit ? 2'd2 : 2'd1;
                  pair.first  = arg_byte(CH_BACKSLASH);
                  pair.second = sq_s.rsp;
                  mode_in     = sq_s.mode;
               end
            end
            MODE_CLOSED: begin
               if (is_blank(c)) begin
                  pair.num   = 2'd1;
                  pair.first = arg_end();
                  mode_in    = MODE_SKIP;
                  count_in   = count_sat;
               end else begin
                  mode_in = MODE_DROP;
               end
            end
            default: begin
               // drop the rest of the line
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_SKIP;
         count_ff <= '0;
      end else if (advance) begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
      end
   end

   assign state.mode  = mode_ff;
   assign state.count = count_ff;

endmodule

`default_nettype wire

>>> hdl/qat_rsp_fifo.sv
// Result queue: takes up to two results per cycle, hands out one per transfer.
`default_nettype none

module qat_rsp_fifo #(
   parameter int unsigned Depth = qat_pkg::QAT_FIFO_DEPTH
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   input  qat_pkg::rsp_pair_type push_pair,
   input  wire                   pop,
   output logic                  head_valid,
   output qat_pkg::rsp_type      head,
   output logic                  room_for_two
);
   import qat_pkg::*;

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);

   rsp_type          mem_ff [Depth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PtrW-1:0]  wr_next, wr_next2, rd_next;
   logic [CntW-1:0]  count_ff, count_in;
   logic [1:0]       push_num;
   logic             do_pop;

   function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
      return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
   endfunction

   assign push_num = push ? push_pair.num : 2'd0;
   assign do_pop   = pop && head_valid;
   assign wr_next  = ptr_inc(wr_ptr_ff);
   assign wr_next2 = ptr_inc(wr_next);
   assign rd_next  = ptr_inc(rd_ptr_ff);

   always_comb begin
      case (push_num)
         2'd1:    wr_ptr_in = wr_next;
         2'd2:    wr_ptr_in = wr_next2;
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = do_pop ? rd_next : rd_ptr_ff;
      count_in  = count_ff + CntW'(push_num) - CntW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_num != 2'd0) mem_ff[wr_ptr_ff] <= push_pair.first;
      if (push_num == 2'd2) mem_ff[wr_next]   <= push_pair.second;
   end

   assign head_valid   = (count_ff != '0);
   assign head         = mem_ff[rd_ptr_ff];
   assign room_for_two = (count_ff <= CntW'(Depth - 2));

endmodule

`default_nettype wire

>>> hdl/quoted_argument_tokenizer.sv
// Quoted argument tokenizer: splits a character stream into shell-style arguments.
//
// req channel: one character (in_byte) or an end-of-line mark (line_end) per
// transfer. A zero character is taken and ignored.
// rsp channel: argument bytes (kind byte), argument-end marks, and at each line
// end one status (ok or error) carrying the saturating argument count.
// Each request makes zero, one or two results. Results appear on rsp in the cycle
// after the request transfer at the earliest; the mode machine handles one
// character per cycle, so requests are taken back to back while req_stall is
// low. The rsp port moves one result per cycle while rsp_stall is low, so a
// stream where requests make two results runs at the rate of the result port.
// A small result queue (FifoDepth entries) sits between the two sides:
// req_stall rises when the queue cannot hold two more results, so a stalled
// receiver backs up into the request side, and nothing is lost or reordered.
// Reset empties the queue and returns the parser to the between-arguments mode
// with a zero count. After an error the rest of the line is dropped and the
// error status is sent at the line end.
`default_nettype none

module quoted_argument_tokenizer #(
   parameter int unsigned FifoDepth = qat_pkg::QAT_FIFO_DEPTH
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  qat_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output qat_pkg::rsp_type  rsp_payload
);
   import qat_pkg::*;

   `include "assert_macros.svh"

   logic            req_take;
   logic            room_for_two;
   rsp_pair_type    pair;
   parse_state_type state;

   assign req_stall = !room_for_two;
   assign req_take  = req_valid && !req_stall;

   qat_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .advance (req_take),
      .item    (req_payload),
      .pair    (pair),
      .state   (state)
   );

   qat_rsp_fifo #(
      .Depth (FifoDepth)
   ) u_rsp_fifo (
      .clock        (clock),
      .reset        (reset),
      .push         (req_take),
      .push_pair    (pair),
      .pop          (!rsp_stall),
      .head_valid   (rsp_valid),
      .head         (rsp_payload),
      .room_for_two (room_for_two)
   );

   `QAT_ASSERT_NEXT(a_line_end_clears, req_take && req_payload.line_end, state.mode == MODE_SKIP && state.count == '0)
   `QAT_ASSERT_IMPL(a_line_end_reports, req_take && req_payload.line_end, pair.num != 2'd0)
   `QAT_ASSERT_IMPL(a_byte_no_count, rsp_valid && rsp_payload.kind == KIND_BYTE, rsp_payload.arg_count == '0)

endmodule

`default_nettype wire
